// ===== hw/rtl/event_coalescing_throttle_assert.svh =====
// Assertion macros shared by the event coalescing throttle RTL
`ifndef EVENT_COALESCING_THROTTLE_ASSERT_SVH
`define EVENT_COALESCING_THROTTLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ECT_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ect assertion failed");

// next-cycle implication, disabled during reset
`define ECT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ect assertion failed");

`endif

// ===== hw/rtl/ect_pkg.sv =====
// Types and constants of the event coalescing throttle
`default_nettype none

package ect_pkg;

    localparam int COUNT_WIDTH_DEF = 20;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CALM_W     = 19;   // holds 5 * 65535

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_IV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [15:0] TICK_IV_RESET  = 16'd100;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [15:0] MIN_HALF_LIMIT = 16'd100;

    typedef enum logic [1:0] {
        MODE_POSTPONE         = 2'd0,
        MODE_FIRST_ACT_POSTPONE = 2'd1,
        MODE_FIRST_ACTIVE     = 2'd2,
        MODE_FIRST_INACTIVE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_SIGNAL = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_STOP   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       idle_now;
    } item_t;

    typedef struct packed {
        logic fire;
        logic active;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/event_coalescing_throttle.sv =====
// Top level of the event coalescing throttle: input stage, core and result register
//
// Input channel: in_valid/in_stall with command (0 signal, 1 ms tick, 2 stop)
// and idle_now. A word is taken at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid/out_stall with fire and active;
// exactly one result word per input word, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 mode, 1 tick interval, 2 timeout); write only while the block is idle.
// Path: a word taken into the input register passes through two register
// stages (input register, result register) before its result shows.
// Throughput: one word per cycle while the receiver does not stall; the state
// update is a loop of compares and a counter increment in the core.
// Reset: the coalescer state clears, mode 0, tick interval 100, timeout 100;
// both stages empty.
// Receiver stall: the result register holds; the input register keeps its
// word and in_stall rises only once both stages are full, so up to two
// words sit in the block while the receiver stalls.
`default_nettype none

module event_coalescing_throttle #(
    parameter int COUNT_WIDTH = ect_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic                          idle_now,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               fire,
    output logic                               active,
    input  wire logic                          cfg_we,
    input  wire logic [ect_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ect_pkg::CFG_W-1:0]     cfg_data
);
    import ect_pkg::*;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    logic    advance;
    logic    step;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg.command  <= command;
            s1_item_reg.idle_now <= idle_now;
        end
    end

    ect_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (s1_item_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign fire      = out_reg.fire;
    assign active    = out_reg.active;

`include "event_coalescing_throttle_assert.svh"

    `ECT_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid_reg && s1_valid_reg)
    `ECT_ASSERT_NEXT(a_step_fills_output, clk, rst_n, step, out_valid_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/ect_core.sv =====
// Coalescer state, configuration registers and per-word update logic
`default_nettype none

module ect_core #(
    parameter int COUNT_WIDTH = ect_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ect_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ect_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                         step,
    input  wire ect_pkg::item_t               item,
    output ect_pkg::result_t                  result
);
    import ect_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CALM_W) ? COUNT_WIDTH : CALM_W;

    mode_t                  mode_reg;
    logic [15:0]            tick_iv_reg;
    logic [15:0]            timeout_reg;

    logic                   running_reg, running_next;
    logic [15:0]            phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] since_reg, since_next;
    logic                   valid_reg, valid_next;
    logic                   pending_reg, pending_next;
    logic                   fire;

    logic [15:0]            min_iv16;
    logic [COUNT_WIDTH-1:0] min_iv;
    logic [CALM_W-1:0]      calm;
    logic [COUNT_WIDTH-1:0] elapsed_now;
    logic [COUNT_WIDTH-1:0] since_inc;
    logic [COUNT_WIDTH-1:0] elapsed_inc;
    logic [16:0]            phase_inc;
    logic [16:0]            iv_eff;
    logic                   first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_POSTPONE;
            tick_iv_reg <= TICK_IV_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= mode_t'(cfg_data[1:0]);
                REG_TICK_IV: tick_iv_reg <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        min_iv16    = (timeout_reg < MIN_HALF_LIMIT) ? {1'b0, timeout_reg[15:1]} : timeout_reg;
        min_iv      = {{(COUNT_WIDTH-16){1'b0}}, min_iv16};
        calm        = ({3'b000, timeout_reg} << 2) + {3'b000, timeout_reg};
        elapsed_now = valid_reg ? since_reg : '0;
        since_inc   = (valid_reg && !(&since_reg)) ? since_reg + 1'b1 : since_reg;
        elapsed_inc = valid_reg ? since_inc : '0;
        phase_inc   = {1'b0, phase_reg} + 17'd1;
        iv_eff      = (tick_iv_reg == 16'd0) ? 17'd1 : {1'b0, tick_iv_reg};
        first       = !running_reg;

        running_next = running_reg;
        phase_next   = phase_reg;
        since_next   = since_reg;
        valid_next   = valid_reg;
        pending_next = pending_reg;
        fire         = 1'b0;

        case (item.command)
            CMD_SIGNAL:
            begin
                if (first)
                begin
                    running_next = 1'b1;
                    phase_next   = '0;
                end
                if (mode_reg == MODE_POSTPONE
                    || (mode_reg == MODE_FIRST_ACT_POSTPONE && !first)
                    || (mode_reg == MODE_FIRST_INACTIVE && first))
                begin
                    since_next   = '0;
                    valid_next   = 1'b1;
                    pending_next = 1'b1;
                end
                else if (first)
                begin
                    // first-active modes fire on the opening signal
                    since_next   = '0;
                    valid_next   = 1'b1;
                    pending_next = 1'b0;
                    fire         = 1'b1;
                end
                else
                begin
                    pending_next = 1'b1;
                    if (elapsed_now >= min_iv || item.idle_now)
                    begin
                        since_next   = '0;
                        valid_next   = 1'b1;
                        pending_next = 1'b0;
                        fire         = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                since_next = since_inc;
                if (running_reg)
                begin
                    phase_next = phase_inc[15:0];
                    if (phase_inc >= iv_eff)
                    begin
                        phase_next = '0;
                        if (pending_reg && (elapsed_inc >= min_iv || item.idle_now))
                        begin
                            since_next   = '0;
                            valid_next   = 1'b1;
                            pending_next = 1'b0;
                            fire         = 1'b1;
                        end
                        else if (!valid_reg || (&since_inc)
                                 || CMP_W'(since_inc) > CMP_W'(calm))
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
            end
            CMD_STOP:
            begin
                running_next = 1'b0;
                phase_next   = '0;
                pending_next = 1'b0;
                since_next   = '0;
                valid_next   = 1'b0;
            end
            default: ;
        endcase

        result.fire   = fire;
        result.active = pending_next && running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= '0;
            since_reg   <= '0;
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            running_reg <= running_next;
            phase_reg   <= phase_next;
            since_reg   <= since_next;
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

`include "event_coalescing_throttle_assert.svh"

    `ECT_ASSERT_NOW(a_invalid_count_zero, clk, rst_n, !valid_reg, since_reg == '0)
    `ECT_ASSERT_NEXT(a_stop_clears, clk, rst_n, step && item.command == CMD_STOP,
        !running_reg && !pending_reg && !valid_reg)
    `ECT_ASSERT_NEXT(a_fire_clears_pending, clk, rst_n, step && result.fire,
        !pending_reg && valid_reg && since_reg == '0)

endmodule

`default_nettype wire

// ===== bench/tb_event_coalescing_throttle.sv =====
// Self-checking bench for event_coalescing_throttle: directed, backpressure and random traffic
module tb_event_coalescing_throttle;
    timeunit 1ns;
    timeprecision 1ps;

    import ect_pkg::*;

    localparam int COUNT_W = COUNT_WIDTH_DEF;
    localparam int CALM_FACTOR = 5;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = CMD_SIGNAL;
    logic idle_now = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic fire;
    logic active;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
    logic [CFG_W-1:0] cfg_data = '0;

    event_coalescing_throttle DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .idle_now(idle_now),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fire(fire),
        .active(active),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // throttle state as predicted from the accepted words
    mode_t mode_r = MODE_POSTPONE;
    logic [15:0] tick_iv_r = TICK_IV_RESET;
    logic [15:0] timeout_r = TIMEOUT_RESET;
    logic run_on = 1'b0;
    logic [15:0] phase_ms = '0;
    logic [COUNT_W-1:0] elapsed_ms = '0;
    logic elapsed_ok = 1'b0;
    logic sig_pending = 1'b0;

    result_t fire_active_q[$];
    int mismatches = 0;
    int hold_req = 0;
    bit gaps_on = 1'b1;
    int burst_left = 8;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_event_coalescing_throttle failed");
        $finish;
    end

    function automatic void restart_elapsed();
        elapsed_ms = '0;
        elapsed_ok = 1'b1;
    endfunction

    // emit succeeds for a pending signal once the minimum spacing has passed or the idle flag allows it
    function automatic logic emit_if_due(logic idle);
        int min_iv;
        int since;
        min_iv = (timeout_r < MIN_HALF_LIMIT) ? int'(timeout_r >> 1) : int'(timeout_r);
        since = elapsed_ok ? int'(elapsed_ms) : 0;
        if (sig_pending && (since >= min_iv || idle))
        begin
            restart_elapsed();
            sig_pending = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t predict_fire_active(logic [1:0] cmd, logic idle);
        result_t r;
        logic first;
        int iv;
        r.fire = 1'b0;
        case (cmd)
            CMD_SIGNAL:
            begin
                first = !run_on;
                if (first)
                begin
                    run_on = 1'b1;
                    phase_ms = '0;
                end
                case (mode_r)
                    MODE_POSTPONE:
                    begin
                        restart_elapsed();
                        sig_pending = 1'b1;
                    end
                    MODE_FIRST_ACT_POSTPONE:
                    begin
                        restart_elapsed();
                        sig_pending = !first;
                        r.fire = first;
                    end
                    MODE_FIRST_ACTIVE:
                    begin
                        if (first)
                        begin
                            restart_elapsed();
                            sig_pending = 1'b0;
                            r.fire = 1'b1;
                        end
                        else
                        begin
                            sig_pending = 1'b1;
                            r.fire = emit_if_due(idle);
                        end
                    end
                    default:
                    begin
                        if (first)
                        begin
                            restart_elapsed();
                            sig_pending = 1'b1;
                        end
                        else
                        begin
                            sig_pending = 1'b1;
                            r.fire = emit_if_due(idle);
                        end
                    end
                endcase
            end
            CMD_TICK:
            begin
                if (elapsed_ok && elapsed_ms != '1)
                    elapsed_ms = elapsed_ms + 1'b1;
                if (run_on)
                begin
                    iv = (tick_iv_r == 16'd0) ? 1 : int'(tick_iv_r);
                    phase_ms = phase_ms + 16'd1;
                    if (int'(phase_ms) >= iv)
                    begin
                        phase_ms = '0;
                        r.fire = emit_if_due(idle);
                        // quiet too long: monitor switches off, pending survives
                        if (!r.fire && (!elapsed_ok || elapsed_ms == '1 ||
                                int'(elapsed_ms) > CALM_FACTOR * int'(timeout_r)))
                            run_on = 1'b0;
                    end
                end
            end
            CMD_STOP:
            begin
                run_on = 1'b0;
                phase_ms = '0;
                sig_pending = 1'b0;
                elapsed_ms = '0;
                elapsed_ok = 1'b0;
            end
            default: ;
        endcase
        r.active = sig_pending && run_on;
        return r;
    endfunction

    // sender bursts: after a random number of words, drop valid for a random gap
    task automatic pace_sender();
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    task automatic send_word(logic [1:0] cmd, logic idle);
        in_valid <= 1'b1;
        command <= cmd;
        idle_now <= idle;
        do
            @(posedge clk);
        while (in_stall);
        fire_active_q.push_back(predict_fire_active(cmd, idle));
        pace_sender();
    endtask

    task automatic send_random_word(int sig_pct);
        int r;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 2)
            cmd = CMD_STOP;
        else if (r < 4)
            cmd = CMD_UNUSED;
        else if (r < 4 + sig_pct)
            cmd = CMD_SIGNAL;
        else
            cmd = CMD_TICK;
        send_word(cmd, $urandom_range(0, 4) == 0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (fire_active_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:    mode_r = mode_t'(data[1:0]);
            REG_TICK_IV: tick_iv_r = data;
            REG_TIMEOUT: timeout_r = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_values();
        send_word(CMD_SIGNAL, 1'b1);
        send_word(CMD_UNUSED, 1'b1);
        send_word(CMD_STOP, 1'b0);
    endtask

    // widest timeout so that only the idle flag lets the second signal through
    task automatic test_each_mode();
        drain_results();
        write_reg(REG_TICK_IV, 16'd1);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        for (int m = 0; m < 4; m++)
        begin
            drain_results();
            write_reg(REG_MODE, {14'd0, m[1:0]});
            send_word(CMD_STOP, 1'b0);
            send_word(CMD_SIGNAL, 1'b0);
            send_word(CMD_SIGNAL, 1'b1);
            send_word(CMD_TICK, 1'b0);
        end
    endtask

    task automatic test_tick_interval_edges();
        drain_results();
        write_reg(REG_MODE, {14'd0, MODE_POSTPONE});
        write_reg(REG_TICK_IV, 16'd0);
        write_reg(REG_TIMEOUT, 16'd0);
        send_word(CMD_SIGNAL, 1'b0);
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_TICK, 1'b0);
        drain_results();
        write_reg(REG_TICK_IV, 16'd6);
        send_word(CMD_STOP, 1'b0);
        send_word(CMD_SIGNAL, 1'b0);
        repeat (3) send_word(CMD_TICK, 1'b0);
        // phase now sits above the lowered interval
        drain_results();
        write_reg(REG_TICK_IV, 16'd2);
        send_word(CMD_TICK, 1'b0);
    endtask

    task automatic test_backpressure();
        bit saved;
        drain_results();
        write_reg(REG_MODE, {14'd0, MODE_FIRST_INACTIVE});
        write_reg(REG_TICK_IV, 16'd3);
        write_reg(REG_TIMEOUT, 16'd4);
        saved = gaps_on;
        gaps_on = 1'b0;
        hold_req = 60;
        repeat (30) send_random_word(30);
        gaps_on = saved;
        // sender waits for every result before going on
        drain_results();
        repeat (10) send_random_word(30);
    endtask

    task automatic test_random_traffic();
        logic [15:0] tick_iv;
        logic [15:0] timeout;
        int sig_pct;
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 4))
                0: tick_iv = 16'd1;
                1: tick_iv = 16'($urandom_range(2, 12));
                2: tick_iv = 16'($urandom_range(13, 60));
                3: tick_iv = 16'd0;
                default: tick_iv = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 4))
                0: timeout = 16'($urandom_range(0, 3));
                1: timeout = 16'($urandom_range(4, 30));
                2: timeout = 16'($urandom_range(98, 101));
                3: timeout = 16'($urandom_range(31, 200));
                default: timeout = 16'($urandom_range(0, 16));
            endcase
            if (p == 0)
            begin
                tick_iv = 16'hFFFF;
                timeout = 16'hFFFF;
            end
            else if (p == 1)
            begin
                tick_iv = 16'd0;
                timeout = 16'd0;
            end
            case ($urandom_range(0, 2))
                0: sig_pct = 5;
                1: sig_pct = 15;
                default: sig_pct = 35;
            endcase
            drain_results();
            write_reg(REG_MODE, {14'($urandom), p[1:0]});
            write_reg(REG_TICK_IV, tick_iv);
            write_reg(REG_TIMEOUT, timeout);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 145; i++)
            begin
                if (i == 72 && $urandom_range(0, 1) == 1)
                    drain_results();
                send_random_word(sig_pct);
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver: stall density changes every span, plus requested long hold-offs
    initial
    begin
        int hold_left;
        int span;
        int pct;
        hold_left = 0;
        span = 0;
        pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (span == 0)
            begin
                span = $urandom_range(20, 150);
                case ($urandom_range(0, 4))
                    0, 1: pct = 0;
                    2: pct = 20;
                    3: pct = 50;
                    default: pct = 85;
                endcase
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    always @(posedge clk)
    begin : check_words
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fire_active_q.size() == 0)
            begin
                $display("%0t: word with nothing expected: fire=%b active=%b",
                         $time, fire, active);
                mismatches++;
            end
            else
            begin
                want = fire_active_q.pop_front();
                if (fire !== want.fire)
                begin
                    $display("%0t: fire expected %b got %b", $time, want.fire, fire);
                    mismatches++;
                end
                if (active !== want.active)
                begin
                    $display("%0t: active expected %b got %b", $time, want.active, active);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_each_mode();
        test_tick_interval_edges();
        test_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (fire_active_q.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (fire_active_q.size() != 0)
        begin
            $display("%0t: %0d words never came out", $time, fire_active_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb_event_coalescing_throttle passed");
        else
            $display("tb_event_coalescing_throttle failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ect_pkg.sv
hw/rtl/ect_core.sv
hw/rtl/event_coalescing_throttle.sv
bench/tb_event_coalescing_throttle.sv
